>>> hdl/tun_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants
// Beat payloads, fixed-point widths and stage counts for the triangle
// unit-normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_WIDTH  = 32;                      // Q16.16 vertex coordinate
  localparam int NORMAL_WIDTH = 16;                      // Q2.14 normal component
  localparam int UNIT_FRAC    = 30;                      // unit edge in Q1.30
  localparam int MAG_W        = 30;                      // normalized magnitude, msb at bit 29
  localparam int SUM_W        = 2 * MAG_W + 2;           // sum of three squares
  localparam int ROOT_W       = SUM_W / 2;               // integer square root
  localparam int QUO_W        = UNIT_FRAC + 1;           // unit magnitude, up to 2^30
  localparam int DIV_W        = MAG_W + UNIT_FRAC + 1;   // dividend with rounding term
  localparam int UNIT_W       = QUO_W + 1;               // signed unit component
  localparam int LZC_W        = $clog2(COORD_WIDTH + 1);
  localparam int EDGE_LAT     = 5 + ROOT_W + 1 + QUO_W + 1;
  localparam int CROSS_LAT    = 3;
  localparam int PIPE_LAT     = EDGE_LAT + CROSS_LAT;

  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef logic signed [NORMAL_WIDTH-1:0] norm_t;
  typedef logic signed [UNIT_W-1:0]       unit_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } in_t;

  typedef struct packed {
    norm_t normal_x;
    norm_t normal_y;
    norm_t normal_z;
    logic  edge_floored;
  } out_t;

  // leading zero count; all zero gives COORD_WIDTH
  function automatic logic [LZC_W-1:0] lzc(input logic [COORD_WIDTH-1:0] v);
    logic [LZC_W-1:0] c;
    c = LZC_W'(COORD_WIDTH);
    for (int i = 0; i < COORD_WIDTH; i++) begin
      if (v[i]) c = LZC_W'(COORD_WIDTH - 1 - i);
    end
    return c;
  endfunction

endpackage

>>> hdl/tun_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_isqrt: pipelined integer square root
// Digit recurrence, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module tun_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tun_pkg::SUM_W-1:0]   sq_sum,
  output logic [tun_pkg::ROOT_W-1:0]  root
);
  import tun_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [REM_W-1:0]  rem_nxt[ROOT_W];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt[ROOT_W];
  logic [SUM_W-1:0]  bits_r  [ROOT_W];
  logic [SUM_W-1:0]  bits_nxt[ROOT_W];

  always_comb begin
    logic [REM_W-1:0]  rem_p;
    logic [REM_W-1:0]  rem_s;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_p;
    logic [SUM_W-1:0]  bits_p;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rem_p  = '0;
        root_p = '0;
        bits_p = sq_sum;
      end else begin
        rem_p  = rem_r[k-1];
        root_p = root_r[k-1];
        bits_p = bits_r[k-1];
      end
      rem_s = {rem_p[REM_W-3:0], bits_p[SUM_W-1 -: 2]};
      trial = {root_p, 2'b01};
      if (rem_s >= trial) begin
        rem_nxt[k]  = rem_s - trial;
        root_nxt[k] = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_s;
        root_nxt[k] = {root_p[ROOT_W-2:0], 1'b0};
      end
      bits_nxt[k] = {bits_p[SUM_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        bits_r[k] <= bits_nxt[k];
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

>>> hdl/tun_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_div: pipelined restoring divider
// One quotient bit per stage; quotient known to fit QUO_W bits.
// ----------------------------------------------------------------------------
module tun_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tun_pkg::DIV_W-1:0]   num,
  input  logic [tun_pkg::ROOT_W-1:0]  den,
  output logic [tun_pkg::QUO_W-1:0]   quo
);
  import tun_pkg::*;

  logic [ROOT_W-1:0] rem_r  [QUO_W];
  logic [ROOT_W-1:0] rem_nxt[QUO_W];
  logic [QUO_W-1:0]  low_r  [QUO_W];
  logic [QUO_W-1:0]  low_nxt[QUO_W];
  logic [QUO_W-1:0]  q_r    [QUO_W];
  logic [QUO_W-1:0]  q_nxt  [QUO_W];
  logic [ROOT_W-1:0] d_r    [QUO_W];
  logic [ROOT_W-1:0] d_nxt  [QUO_W];

  always_comb begin
    logic [ROOT_W-1:0] rem_p;
    logic [ROOT_W:0]   rem_s;
    logic [QUO_W-1:0]  low_p;
    logic [QUO_W-1:0]  q_p;
    logic [ROOT_W-1:0] d_p;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        rem_p = ROOT_W'(num[DIV_W-1:QUO_W]);
        low_p = num[QUO_W-1:0];
        q_p   = '0;
        d_p   = den;
      end else begin
        rem_p = rem_r[k-1];
        low_p = low_r[k-1];
        q_p   = q_r[k-1];
        d_p   = d_r[k-1];
      end
      rem_s = {rem_p, low_p[QUO_W-1]};
      if (rem_s >= {1'b0, d_p}) begin
        rem_nxt[k] = ROOT_W'(rem_s - {1'b0, d_p});
        q_nxt[k]   = {q_p[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = ROOT_W'(rem_s);
        q_nxt[k]   = {q_p[QUO_W-2:0], 1'b0};
      end
      low_nxt[k] = {low_p[QUO_W-2:0], 1'b0};
      d_nxt[k]   = d_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        q_r[k]   <= q_nxt[k];
        d_r[k]   <= d_nxt[k];
      end
    end
  end

  assign quo = q_r[QUO_W-1];

endmodule

>>> hdl/tun_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_edge: unit edge p - q in Q1.30
// Difference, normalize, sum of squares, square root, three dividers, sign.
// ----------------------------------------------------------------------------
module tun_edge (
  input  logic            clk,
  input  logic            en,
  input  tun_pkg::coord_t p_x,
  input  tun_pkg::coord_t p_y,
  input  tun_pkg::coord_t p_z,
  input  tun_pkg::coord_t q_x,
  input  tun_pkg::coord_t q_y,
  input  tun_pkg::coord_t q_z,
  output tun_pkg::unit_t  u_x,
  output tun_pkg::unit_t  u_y,
  output tun_pkg::unit_t  u_z,
  output logic            floored
);
  import tun_pkg::*;

  localparam int MN_D  = ROOT_W + 2;              // normalized mags to divider prep
  localparam int NEG_D = 4 + ROOT_W + 1 + QUO_W;  // signs to sign stage
  localparam int ZF_D  = NEG_D;                   // zero flag to output

  coord_t pv [3];
  coord_t qv [3];

  logic [2:0][COORD_WIDTH-1:0] mag_nxt, mag_r, mag2_r;
  logic [2:0]                  neg_nxt, neg_r;
  logic [LZC_W-1:0]            lz_r;
  logic                        zero_r;
  logic [2:0][MAG_W-1:0]       mn_nxt, mn_r;
  logic [2:0][2*MAG_W-1:0]     sq_r;
  logic [SUM_W-1:0]            sum_r;
  logic [ROOT_W-1:0]           root;
  logic [ROOT_W-1:0]           den;
  logic [ROOT_W-1:0]           den_r;
  logic [2:0][DIV_W-1:0]       num_r;
  logic [2:0][QUO_W-1:0]       quo;
  logic [2:0][UNIT_W-1:0]      u_nxt, u_r;

  logic [2:0][MAG_W-1:0]       mnd_r [MN_D];
  logic [2:0]                  nd_r  [NEG_D];
  logic                        zd_r  [ZF_D];

  assign pv[0] = p_x;
  assign pv[1] = p_y;
  assign pv[2] = p_z;
  assign qv[0] = q_x;
  assign qv[1] = q_y;
  assign qv[2] = q_z;

  // stage 1: exact difference as sign and magnitude
  always_comb begin
    logic signed [COORD_WIDTH:0] dif;
    for (int i = 0; i < 3; i++) begin
      dif        = {pv[i][COORD_WIDTH-1], pv[i]} - {qv[i][COORD_WIDTH-1], qv[i]};
      neg_nxt[i] = dif[COORD_WIDTH];
      mag_nxt[i] = dif[COORD_WIDTH] ? COORD_WIDTH'(-dif) : COORD_WIDTH'(dif);
    end
  end

  // stage 3: common shift so the largest lands with msb at bit MAG_W-1
  always_comb begin
    logic [COORD_WIDTH+MAG_W-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      ext       = {mag2_r[i], MAG_W'(0)} << lz_r;
      mn_nxt[i] = ext[COORD_WIDTH+MAG_W-1 -: MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
      mag2_r <= mag_r;
      lz_r   <= lzc(mag_r[0] | mag_r[1] | mag_r[2]);
      zero_r <= ((mag_r[0] | mag_r[1] | mag_r[2]) == '0);
      mn_r   <= mn_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= mn_r[i] * mn_r[i];
      end
      sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  tun_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .sq_sum (sum_r),
    .root   (root)
  );

  // sideband delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      mnd_r[0] <= mn_r;
      for (int k = 1; k < MN_D; k++) mnd_r[k] <= mnd_r[k-1];
      nd_r[0] <= neg_r;
      for (int k = 1; k < NEG_D; k++) nd_r[k] <= nd_r[k-1];
      zd_r[0] <= zero_r;
      for (int k = 1; k < ZF_D; k++) zd_r[k] <= zd_r[k-1];
    end
  end

  // divider prep: round-half-up numerator, zero length treated as one
  assign den = (root == '0) ? ROOT_W'(1) : root;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den;
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= DIV_W'({mnd_r[MN_D-1][i], UNIT_FRAC'(0)}) + DIV_W'(den >> 1);
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    tun_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[g]),
      .den (den_r),
      .quo (quo[g])
    );
  end

  always_comb begin
    logic [UNIT_W-1:0] uu;
    for (int i = 0; i < 3; i++) begin
      uu       = {1'b0, quo[i]};
      u_nxt[i] = nd_r[NEG_D-1][i] ? UNIT_W'(-uu) : uu;
    end
  end

  always_ff @(posedge clk) begin
    if (en) u_r <= u_nxt;
  end

  assign u_x     = unit_t'(u_r[0]);
  assign u_y     = unit_t'(u_r[1]);
  assign u_z     = unit_t'(u_r[2]);
  assign floored = zd_r[ZF_D-1];

endmodule

>>> hdl/tun_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_cross: cross product of two unit edges
// Products, difference with rounding term, shift and saturate to Q2.14.
// ----------------------------------------------------------------------------
module tun_cross (
  input  logic            clk,
  input  logic            en,
  input  tun_pkg::unit_t  u_x,
  input  tun_pkg::unit_t  u_y,
  input  tun_pkg::unit_t  u_z,
  input  tun_pkg::unit_t  v_x,
  input  tun_pkg::unit_t  v_y,
  input  tun_pkg::unit_t  v_z,
  input  logic            flag_in,
  output tun_pkg::norm_t  n_x,
  output tun_pkg::norm_t  n_y,
  output tun_pkg::norm_t  n_z,
  output logic            flag_out
);
  import tun_pkg::*;

  localparam int P_W = 2 * UNIT_W;
  localparam int R_W = P_W + 2;
  localparam int SH  = 2 * UNIT_FRAC - (NORMAL_WIDTH - 2);
  localparam logic signed [R_W-1:0] RND = R_W'(1) << (SH - 1);
  localparam logic signed [R_W-1:0] HI  = (R_W'(1) << (NORMAL_WIDTH - 1)) - R_W'(1);
  localparam logic signed [R_W-1:0] LO  = -HI - R_W'(1);

  logic signed [P_W-1:0] p_r [6];
  logic signed [R_W-1:0] d_r [3];
  norm_t                 n_r [3];
  logic [CROSS_LAT-1:0]  fd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= u_y * v_z;
      p_r[1] <= u_z * v_y;
      p_r[2] <= u_z * v_x;
      p_r[3] <= u_x * v_z;
      p_r[4] <= u_x * v_y;
      p_r[5] <= u_y * v_x;
      for (int j = 0; j < 3; j++) begin
        d_r[j] <= R_W'(p_r[2*j]) - R_W'(p_r[2*j+1]) + RND;
      end
      fd_r <= {fd_r[CROSS_LAT-2:0], flag_in};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [R_W-1:0] t;
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        t = d_r[j] >>> SH;
        if (t > HI)      n_r[j] <= NORMAL_WIDTH'(HI);
        else if (t < LO) n_r[j] <= NORMAL_WIDTH'(LO);
        else             n_r[j] <= NORMAL_WIDTH'(t);
      end
    end
  end

  assign n_x      = n_r[0];
  assign n_y      = n_r[1];
  assign n_z      = n_r[2];
  assign flag_out = fd_r[CROSS_LAT-1];

endmodule

>>> hdl/triangle_unit_normal_top.sv
`timescale 1ns / 1ps
// Path: an accepted input beat crosses 72 pipeline stages and then the output
//   register before out_valid, and is held up only while the skid is full.
// Throughput: one triangle per cycle while the skid register is empty; the
//   square root and the dividers are fully pipelined, one bit per stage.
// Reset: synchronous active-low rst_n clears the stage valid bits, output and
//   skid flags; no memories, no clearing pass.
// ----------------------------------------------------------------------------
// triangle_unit_normal_top: face normal from two unit edges
// Edges a-b and c-b are scaled to unit length in Q1.30, crossed, and the
// result is rounded half up and saturated to Q2.14. edge_floored flags an
// all-zero edge, which yields a zero normal.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tun_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tun_pkg::out_t out_data
);
  import tun_pkg::*;

  // Every stage moves on a single enable. The enable only drops when the
  // skid register holds a beat, so it comes straight from a flop.
  logic                en;
  logic [PIPE_LAT-1:0] vld_r;
  logic                push;

  unit_t u_x, u_y, u_z;
  unit_t v_x, v_y, v_z;
  logic  fl_u, fl_v;
  out_t  pipe_data;

  logic  out_valid_r;
  out_t  out_data_r;
  logic  skid_v_r;
  out_t  skid_data_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // valid bits ride along with the data stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // e1 = a - b
  tun_edge u_edge1 (
    .clk     (clk),
    .en      (en),
    .p_x     (in_data.a_x),
    .p_y     (in_data.a_y),
    .p_z     (in_data.a_z),
    .q_x     (in_data.b_x),
    .q_y     (in_data.b_y),
    .q_z     (in_data.b_z),
    .u_x     (u_x),
    .u_y     (u_y),
    .u_z     (u_z),
    .floored (fl_u)
  );

  // e2 = c - b
  tun_edge u_edge2 (
    .clk     (clk),
    .en      (en),
    .p_x     (in_data.c_x),
    .p_y     (in_data.c_y),
    .p_z     (in_data.c_z),
    .q_x     (in_data.b_x),
    .q_y     (in_data.b_y),
    .q_z     (in_data.b_z),
    .u_x     (v_x),
    .u_y     (v_y),
    .u_z     (v_z),
    .floored (fl_v)
  );

  tun_cross u_cross (
    .clk      (clk),
    .en       (en),
    .u_x      (u_x),
    .u_y      (u_y),
    .u_z      (u_z),
    .v_x      (v_x),
    .v_y      (v_y),
    .v_z      (v_z),
    .flag_in  (fl_u | fl_v),
    .n_x      (pipe_data.normal_x),
    .n_y      (pipe_data.normal_y),
    .n_z      (pipe_data.normal_z),
    .flag_out (pipe_data.edge_floored)
  );

  // last stage hands its beat on at every enabled edge
  assign push = en && vld_r[PIPE_LAT-1];

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_v_r ? skid_data_r : pipe_data;
    end else if (push) begin
      skid_data_r <= pipe_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/tun_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_checker: port-level checks for the unit-normal block
// Output handshake, reset behavior and the floored-edge result.
// ----------------------------------------------------------------------------
module tun_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input tun_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input tun_pkg::out_t out_data
);
  import tun_pkg::*;

  // a held result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a held result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // a floored edge gives a zero normal
  a_floor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.edge_floored |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("floored edge with nonzero normal");

endmodule

bind triangle_unit_normal_top tun_checker u_tun_checker (.*);

>>> tb/triangle_unit_normal_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_top_test: face-normal pipeline testbench
// Drives vertex triples through the valid/ready input, predicts each normal
// with a bit-exact model of the edge normalization and cross product, and
// checks every output beat in order under random idling on both sides.
// ----------------------------------------------------------------------------

class normal_scoreboard;
  tun_pkg::out_t pending[$];
  int            errors;

  // sign and magnitude of p - q, exact
  static function automatic void edge_diff(input tun_pkg::coord_t p, input tun_pkg::coord_t q,
                                           output logic [32:0] mag, output bit neg);
    logic signed [33:0] d;
    d = 34'(p) - 34'(q);
    neg = d < 0;
    mag = neg ? 33'(-d) : 33'(d);
  endfunction

  static function automatic logic [31:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv, r;
    res = 0;
    bitv = 64'd1 << 62;
    r = x;
    while (bitv > r) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (r >= res + bitv) begin
        r = r - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // unit edge in Q1.30; returns 1 for an all-zero edge
  static function automatic bit unit_edge(input tun_pkg::coord_t p[3], input tun_pkg::coord_t q[3],
                                          output longint u[3]);
    logic [32:0] m[3];
    logic [63:0] mm[3], s, n, um;
    logic [32:0] top;
    bit neg[3];
    int pos;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      edge_diff(p[i], q[i], m[i], neg[i]);
      top |= m[i];
    end
    if (top == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return 1;
    end
    pos = 0;
    for (int b = 0; b < 33; b++) if (top[b]) pos = b;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mm[i] = 64'(m[i]);
      if (pos > 29) mm[i] = mm[i] >> (pos - 29);
      else mm[i] = mm[i] << (29 - pos);
      s += mm[i] * mm[i];
    end
    n = 64'(int_sqrt(s));
    if (n == 0) n = 1;
    for (int i = 0; i < 3; i++) begin
      um = ((mm[i] << 30) + (n >> 1)) / n;
      u[i] = neg[i] ? -longint'(um) : longint'(um);
    end
    return 0;
  endfunction

  // Q2.60 to Q2.14, round half up, saturate
  static function automatic tun_pkg::norm_t to_q214(input logic signed [127:0] c);
    logic signed [127:0] r;
    r = (c + (128'sd1 <<< 45)) >>> 46;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic tun_pkg::out_t face_normal(input tun_pkg::in_t t);
    tun_pkg::coord_t a[3], b[3], c[3];
    longint u[3], v[3];
    logic signed [127:0] uu[3], vv[3];
    bit f1, f2;
    tun_pkg::out_t o;
    a = '{t.a_x, t.a_y, t.a_z};
    b = '{t.b_x, t.b_y, t.b_z};
    c = '{t.c_x, t.c_y, t.c_z};
    f1 = unit_edge(a, b, u);
    f2 = unit_edge(c, b, v);
    for (int i = 0; i < 3; i++) begin
      uu[i] = 128'(u[i]);
      vv[i] = 128'(v[i]);
    end
    o.normal_x = to_q214(uu[1] * vv[2] - uu[2] * vv[1]);
    o.normal_y = to_q214(uu[2] * vv[0] - uu[0] * vv[2]);
    o.normal_z = to_q214(uu[0] * vv[1] - uu[1] * vv[0]);
    o.edge_floored = f1 | f2;
    return o;
  endfunction

  function void note_triangle(input tun_pkg::in_t t);
    pending.push_back(face_normal(t));
  endfunction

  function void check_normal(input tun_pkg::out_t got);
    tun_pkg::out_t exp_n;
    if (pending.size() == 0) begin
      $error("normal beat with none pending: %h", got);
      errors++;
      return;
    end
    exp_n = pending.pop_front();
    if (got.normal_x !== exp_n.normal_x) begin
      $error("normal_x: expected %0d, got %0d", exp_n.normal_x, got.normal_x);
      errors++;
    end
    if (got.normal_y !== exp_n.normal_y) begin
      $error("normal_y: expected %0d, got %0d", exp_n.normal_y, got.normal_y);
      errors++;
    end
    if (got.normal_z !== exp_n.normal_z) begin
      $error("normal_z: expected %0d, got %0d", exp_n.normal_z, got.normal_z);
      errors++;
    end
    if (got.edge_floored !== exp_n.edge_floored) begin
      $error("edge_floored: expected %0b, got %0b", exp_n.edge_floored, got.edge_floored);
      errors++;
    end
  endfunction
endclass

module triangle_unit_normal_top_test;
  import tun_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  normal_scoreboard sb = new();
  bit   no_idle = 1'b0;   // long stretch with both sides busy
  bit   sending_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_unit_normal_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Sample both channels at the rising edge; the scoreboard sees beats in
  // acceptance order.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_triangle(in_data);
    if (rst_n && out_valid && out_ready) sb.check_normal(out_data);
  end

  // Receiver stalls about 26 percent of cycles, none during the busy stretch.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(99) >= 26);
  end

  // Push one triangle; valid holds until the beat is taken. Random gaps go
  // before the beat so idling hits every pipeline phase. Valid drops only
  // in an idle cycle, so back-to-back beats keep it high.
  task automatic send_triangle(input in_t t);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic coord_t pick_coord(input int mode);
    case (mode)
      0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1: return coord_t'($urandom_range(7)) - 4;          // a few LSBs
      2: return coord_t'($urandom_range(2047)) - 1024;
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic in_t random_triangle();
    in_t t;
    int mode;
    mode = $urandom_range(3);
    t.a_x = pick_coord(mode); t.a_y = pick_coord(mode); t.a_z = pick_coord(mode);
    t.b_x = pick_coord(mode); t.b_y = pick_coord(mode); t.b_z = pick_coord(mode);
    t.c_x = pick_coord(mode); t.c_y = pick_coord(mode); t.c_z = pick_coord(mode);
    case ($urandom_range(15))
      0: begin t.a_x = t.b_x; t.a_y = t.b_y; t.a_z = t.b_z; end   // zero first edge
      1: begin t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z; end   // zero edge c - b
      2: begin                                                     // collinear edges
        t.c_x = t.b_x - (t.a_x - t.b_x);
        t.c_y = t.b_y - (t.a_y - t.b_y);
        t.c_z = t.b_z - (t.a_z - t.b_z);
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic in_t tri9(input coord_t ax, ay, az, bx, by, bz, cx, cy, cz);
    in_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    return t;
  endfunction

  localparam coord_t ONE  = 32'sh00010000;
  localparam coord_t CMAX = 32'sh7fffffff;
  localparam coord_t CMIN = 32'sh80000000;

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: unit axes both orders, degenerate edges, range extremes
    send_triangle(tri9(ONE, 0, 0, 0, 0, 0, 0, ONE, 0));
    send_triangle(tri9(0, ONE, 0, 0, 0, 0, ONE, 0, 0));
    send_triangle(tri9(0, 0, ONE, 0, 0, 0, ONE, 0, 0));
    send_triangle(tri9(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(tri9(5, 6, 7, 5, 6, 7, 1, 2, 3));
    send_triangle(tri9(1, 2, 3, 5, 6, 7, 5, 6, 7));
    send_triangle(tri9(2, 4, 6, 0, 0, 0, 4, 8, 12));
    send_triangle(tri9(1, 0, 0, 0, 0, 0, 0, 1, 0));
    send_triangle(tri9(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN));
    send_triangle(tri9(CMIN, 0, 0, CMAX, 0, 0, CMAX, CMIN, 0));
    send_triangle(tri9(CMAX, 0, CMIN, 0, CMAX, 0, CMIN, CMIN, CMAX));
    send_triangle(tri9(-1, -1, -1, 0, 0, 0, 1, -1, 0));
    send_triangle(tri9(CMAX, 1, 0, CMIN, 0, 0, 0, CMAX, 0));
    send_triangle(tri9(-ONE, ONE, 3, 7, -9, CMIN, CMAX, 0, -1));
    in_valid <= 1'b0;

    // pause until the pipeline drains
    while (sb.pending.size() != 0) @(negedge clk);

    for (int i = 0; i < 1500; i++) begin
      no_idle = (i >= 600 && i < 800);
      send_triangle(random_triangle());
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog: far above the slowest legal run
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
